[hdl/swsn_pkg.sv]
// Shared constants and types for the skin weight sort and normalize block.
// No dependencies; every other file in hdl/ imports this package.
package swsn_pkg;

    localparam int SLOTS         = 4;
    localparam int BONE_BITS_DEF = 8;
    localparam int WEIGHT_BITS   = 16;
    localparam int COUNT_BITS    = 3;
    localparam int Q_BITS        = 16;
    localparam int Q_ONE         = 32768;
    localparam int MW            = WEIGHT_BITS + $clog2(SLOTS);
    localparam int NW            = $clog2(SLOTS + 1);
    localparam int RW            = $clog2(SLOTS);
    localparam int ADDR_BITS     = 3;

    localparam logic [WEIGHT_BITS-1:0] THR_RESET  = 16'd1638;
    localparam logic [COUNT_BITS-1:0]  MAXI_RESET = 3'd4;

    typedef logic [MW-1:0] mweight_t;
    typedef logic [NW-1:0] count_t;

    typedef enum logic {
        REG_DROP_THRESHOLD = 1'b0,
        REG_MAX_INFLUENCES = 1'b1
    } reg_idx_t;

endpackage

[hdl/swsn_sort.sv]
// Stable descending rank sort of the merged influences, one comparator per pair.
// Depends on swsn_pkg.
module swsn_sort #(
    parameter int BONE_BITS = swsn_pkg::BONE_BITS_DEF
) (
    input  swsn_pkg::mweight_t w_in  [swsn_pkg::SLOTS],
    input  logic [BONE_BITS-1:0] b_in [swsn_pkg::SLOTS],
    input  swsn_pkg::count_t   n,
    output swsn_pkg::mweight_t w_out [swsn_pkg::SLOTS],
    output logic [BONE_BITS-1:0] b_out [swsn_pkg::SLOTS]
);
    import swsn_pkg::*;

    logic [RW-1:0]    rank [SLOTS];
    logic [SLOTS-1:0] valid;

    // Rank each valid pair: heavier pairs and equal earlier pairs go first
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            valid[i] = (NW'(i) < n);
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < SLOTS; j++)
            begin
                if (j != i && valid[j] &&
                    ((w_in[j] > w_in[i]) || (w_in[j] == w_in[i] && j < i)))
                begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
        end
    end

    // Scatter each pair to its ranked slot; empty slots hold zero
    always_comb
    begin
        for (int p = 0; p < SLOTS; p++)
        begin
            w_out[p] = '0;
            b_out[p] = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (valid[i] && rank[i] == RW'(p))
                begin
                    w_out[p] = w_in[i];
                    b_out[p] = b_in[i];
                end
            end
        end
    end

endmodule

[hdl/swsn_div_lane.sv]
// One lane of the normalizer: pipelined restoring divider, one quotient bit per stage.
// Depends on swsn_pkg. Quotient must fit Q_BITS bits (num < den << Q_BITS).
module swsn_div_lane #(
    parameter int DW = swsn_pkg::MW
) (
    input  logic                               clk,
    input  logic [swsn_pkg::Q_BITS-1:0]        en,
    input  logic [DW+swsn_pkg::Q_BITS-2:0]     num,
    input  logic [DW-1:0]                      den,
    output logic [swsn_pkg::Q_BITS-1:0]        quo
);
    import swsn_pkg::*;

    logic [DW-1:0]     r_reg  [Q_BITS];
    logic [DW-1:0]     r_next [Q_BITS];
    logic [Q_BITS-1:0] lo_reg [Q_BITS];
    logic [DW-1:0]     d_reg  [Q_BITS];
    logic [Q_BITS-1:0] q_reg  [Q_BITS];
    logic [DW-1:0]     r_in   [Q_BITS];
    logic [Q_BITS-1:0] lo_in  [Q_BITS];
    logic [DW-1:0]     d_in   [Q_BITS];
    logic [Q_BITS-1:0] q_in   [Q_BITS];
    logic [Q_BITS-1:0] ge;

    for (genvar k = 0; k < Q_BITS; k++)
    begin : g_stage
        // Take the first stage from the operands, later ones from the stage before
        if (k == 0)
        begin : g_first
            assign r_in[k]  = {1'b0, num[DW+Q_BITS-2:Q_BITS]};
            assign lo_in[k] = num[Q_BITS-1:0];
            assign d_in[k]  = den;
            assign q_in[k]  = '0;
        end
        else
        begin : g_next
            assign r_in[k]  = r_reg[k-1];
            assign lo_in[k] = lo_reg[k-1];
            assign d_in[k]  = d_reg[k-1];
            assign q_in[k]  = q_reg[k-1];
        end

        // Shift in one numerator bit, subtract when the divisor fits
        always_comb
        begin
            logic [DW:0] t;
            t        = {r_in[k], lo_in[k][Q_BITS-1]};
            ge[k]    = (t >= {1'b0, d_in[k]});
            r_next[k] = ge[k] ? DW'(t - {1'b0, d_in[k]}) : DW'(t);
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                r_reg[k]  <= r_next[k];
                lo_reg[k] <= {lo_in[k][Q_BITS-2:0], 1'b0};
                d_reg[k]  <= d_in[k];
                q_reg[k]  <= {q_in[k][Q_BITS-2:0], ge[k]};
            end
        end
    end

    assign quo = q_reg[Q_BITS-1];

endmodule

[hdl/skin_weight_sort_normalize.sv]
// Top level of the skin weight sort and normalize block: input register, duplicate
// merge, sort, trim and sum, then one divider lane per slot. Depends on swsn_pkg,
// swsn_sort and swsn_div_lane.
//
// Takes one vertex item per clock unless in_stall is high and returns one result per
// item through four front stages (input, merge, sort, trim and sum), sixteen stages
// of the per-slot dividers that produce one quotient bit each, and the output
// register. Empty stages are squeezed out, so a stall on the output only holds the
// input once every stage holds an item. Write drop_threshold at byte address 0 and
// max_influences at address 4 while no item is in flight.
module skin_weight_sort_normalize #(
    parameter int BONE_INDEX_BITS = swsn_pkg::BONE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [swsn_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [swsn_pkg::COUNT_BITS-1:0]      entry_count,
    input  logic [BONE_INDEX_BITS-1:0]           bone_0,
    input  logic [swsn_pkg::WEIGHT_BITS-1:0]     weight_0,
    input  logic [BONE_INDEX_BITS-1:0]           bone_1,
    input  logic [swsn_pkg::WEIGHT_BITS-1:0]     weight_1,
    input  logic [BONE_INDEX_BITS-1:0]           bone_2,
    input  logic [swsn_pkg::WEIGHT_BITS-1:0]     weight_2,
    input  logic [BONE_INDEX_BITS-1:0]           bone_3,
    input  logic [swsn_pkg::WEIGHT_BITS-1:0]     weight_3,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [swsn_pkg::COUNT_BITS-1:0]      kept_count,
    output logic [BONE_INDEX_BITS-1:0]           out_bone_0,
    output logic [swsn_pkg::WEIGHT_BITS-1:0]     out_weight_0,
    output logic [BONE_INDEX_BITS-1:0]           out_bone_1,
    output logic [swsn_pkg::WEIGHT_BITS-1:0]     out_weight_1,
    output logic [BONE_INDEX_BITS-1:0]           out_bone_2,
    output logic [swsn_pkg::WEIGHT_BITS-1:0]     out_weight_2,
    output logic [BONE_INDEX_BITS-1:0]           out_bone_3,
    output logic [swsn_pkg::WEIGHT_BITS-1:0]     out_weight_3
);
    import swsn_pkg::*;

    localparam int FRONT = 4;
    localparam int OUTS  = FRONT + Q_BITS;
    localparam int NST   = OUTS + 1;
    localparam int NUMW  = MW + Q_BITS - 1;

    typedef logic [BONE_INDEX_BITS-1:0] bone_t;

    // Configuration registers
    logic [WEIGHT_BITS-1:0] thr_reg;
    logic [COUNT_BITS-1:0]  maxi_reg;

    // Stage control
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    // Front stages
    bone_t                  b_in [SLOTS];
    logic [WEIGHT_BITS-1:0] w_in [SLOTS];
    count_t                 n0_next, n0_reg, n1_reg, n2_reg, n3_next, n3_reg;
    bone_t                  b0_reg [SLOTS];
    logic [WEIGHT_BITS-1:0] w0_reg [SLOTS];
    mweight_t               w1_next [SLOTS];
    mweight_t               w1_reg  [SLOTS];
    bone_t                  b1_reg  [SLOTS];
    mweight_t               w2_next [SLOTS];
    bone_t                  b2_next [SLOTS];
    mweight_t               w2_reg  [SLOTS];
    bone_t                  b2_reg  [SLOTS];
    mweight_t               w3_reg  [SLOTS];
    bone_t                  b3_reg  [SLOTS];
    mweight_t               sum3_next, sum3_reg;
    count_t                 lim;

    // Divider lanes and their side line
    logic [NUMW-1:0]        num   [SLOTS];
    mweight_t               den   [SLOTS];
    logic [Q_BITS-1:0]      quo   [SLOTS];
    bone_t                  bp_reg [Q_BITS][SLOTS];
    count_t                 np_reg [Q_BITS];

    // Output register
    count_t                 no_reg;
    bone_t                  bo_reg [SLOTS];
    logic [WEIGHT_BITS-1:0] wo_reg [SLOTS];

    // Configuration port
    assign pready = 1'b1;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_DROP_THRESHOLD: prdata = 32'(thr_reg);
            REG_MAX_INFLUENCES: prdata = 32'(maxi_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            maxi_reg <= MAXI_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_DROP_THRESHOLD: thr_reg  <= pwdata[WEIGHT_BITS-1:0];
                REG_MAX_INFLUENCES: maxi_reg <= pwdata[COUNT_BITS-1:0];
                default:            thr_reg  <= thr_reg;
            endcase
        end
    end

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        en[OUTS] = !v_reg[OUTS] || !out_stall;
        for (int k = OUTS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[OUTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Input stage: clamp the count and hold the pairs
    assign b_in[0] = bone_0;
    assign b_in[1] = bone_1;
    assign b_in[2] = bone_2;
    assign b_in[3] = bone_3;
    assign w_in[0] = weight_0;
    assign w_in[1] = weight_1;
    assign w_in[2] = weight_2;
    assign w_in[3] = weight_3;

    always_comb
    begin
        if (entry_count == '0)
            n0_next = NW'(1);
        else if (32'(entry_count) > 32'(SLOTS))
            n0_next = NW'(SLOTS);
        else
            n0_next = NW'(entry_count);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            n0_reg <= n0_next;
            b0_reg <= b_in;
            w0_reg <= w_in;
        end
    end

    // Merge stage: fold later duplicates into the first pair with that bone
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            logic     dup;
            mweight_t acc;
            dup = 1'b0;
            acc = '0;
            for (int k = 0; k < i; k++)
            begin
                if (b0_reg[k] == b0_reg[i])
                    dup = 1'b1;
            end
            for (int j = i; j < SLOTS; j++)
            begin
                if (NW'(j) < n0_reg && b0_reg[j] == b0_reg[i])
                    acc = acc + MW'(w0_reg[j]);
            end
            w1_next[i] = dup ? '0 : acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            n1_reg <= n0_reg;
            b1_reg <= b0_reg;
            w1_reg <= w1_next;
        end
    end

    // Sort stage
    swsn_sort #(
        .BONE_BITS (BONE_INDEX_BITS)
    ) u_sort (
        .w_in  (w1_reg),
        .b_in  (b1_reg),
        .n     (n1_reg),
        .w_out (w2_next),
        .b_out (b2_next)
    );

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            n2_reg <= n1_reg;
            b2_reg <= b2_next;
            w2_reg <= w2_next;
        end
    end

    // Trim stage: drop light trailing pairs, clip, and sum what is kept
    always_comb
    begin
        if (maxi_reg == '0)
            lim = NW'(1);
        else if (32'(maxi_reg) > 32'(SLOTS))
            lim = NW'(SLOTS);
        else
            lim = NW'(maxi_reg);

        n3_next = '0;
        for (int p = 0; p < SLOTS; p++)
        begin
            if (NW'(p) < n2_reg && w2_reg[p] >= MW'(thr_reg))
                n3_next = n3_next + 1'b1;
        end
        if (n3_next == '0)
            n3_next = NW'(1);
        if (n3_next > lim)
            n3_next = lim;

        sum3_next = '0;
        for (int p = 0; p < SLOTS; p++)
        begin
            if (NW'(p) < n3_next)
                sum3_next = sum3_next + w2_reg[p];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            n3_reg   <= n3_next;
            b3_reg   <= b2_reg;
            w3_reg   <= w2_reg;
            sum3_reg <= sum3_next;
        end
    end

    // Divider lanes: weight over sum, or an equal share when the sum is zero
    for (genvar p = 0; p < SLOTS; p++)
    begin : g_lane
        assign num[p] = (sum3_reg == '0) ? NUMW'(Q_ONE)
                                         : {w3_reg[p], (Q_BITS-1)'(0)};
        assign den[p] = (sum3_reg == '0) ? MW'(n3_reg) : sum3_reg;

        swsn_div_lane #(
            .DW (MW)
        ) u_div (
            .clk (clk),
            .en  (en[OUTS-1:FRONT]),
            .num (num[p]),
            .den (den[p]),
            .quo (quo[p])
        );
    end

    // Carry bones and count alongside the dividers
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < Q_BITS; k++)
        begin
            if (en[FRONT+k])
            begin
                if (k == 0)
                begin
                    bp_reg[k] <= b3_reg;
                    np_reg[k] <= n3_reg;
                end
                else
                begin
                    bp_reg[k] <= bp_reg[k-1];
                    np_reg[k] <= np_reg[k-1];
                end
            end
        end
    end

    // Output register: blank the slots past the kept count
    always_ff @(posedge clk)
    begin
        if (en[OUTS])
        begin
            no_reg <= np_reg[Q_BITS-1];
            for (int p = 0; p < SLOTS; p++)
            begin
                if (NW'(p) < np_reg[Q_BITS-1])
                begin
                    bo_reg[p] <= bp_reg[Q_BITS-1][p];
                    wo_reg[p] <= quo[p];
                end
                else
                begin
                    bo_reg[p] <= '0;
                    wo_reg[p] <= '0;
                end
            end
        end
    end

    assign kept_count   = COUNT_BITS'(no_reg);
    assign out_bone_0   = bo_reg[0];
    assign out_weight_0 = wo_reg[0];
    assign out_bone_1   = bo_reg[1];
    assign out_weight_1 = wo_reg[1];
    assign out_bone_2   = bo_reg[2];
    assign out_weight_2 = wo_reg[2];
    assign out_bone_3   = bo_reg[3];
    assign out_weight_3 = wo_reg[3];

`ifndef SYNTHESIS
    // A kept count is never zero and never above the slot count
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (no_reg != '0 && 32'(no_reg) <= 32'(SLOTS)))
        else $error("kept count out of range");

    // Normalized weights never sum above one
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(wo_reg[0]) + 32'(wo_reg[1]) + 32'(wo_reg[2])
                       + 32'(wo_reg[3]) <= 32'(Q_ONE)))
        else $error("normalized weights exceed one");

    // The heaviest kept slot always carries weight
    a_first_weight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (wo_reg[0] != '0))
        else $error("first kept weight is zero");

    // An empty input stage never stalls the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> !in_stall)
        else $error("input stalled with an empty input stage");
`endif

endmodule
